/* rtl/dvdlpcm_pkg.sv */
// Shared types, codes and lookup functions for the DVD LPCM stream decoder.
// No dependencies; every other file imports this package.
package dvdlpcm_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [2:0]         channel;
    logic [4:0]         depth_bits;
    logic [16:0]        rate_hz;
    logic [3:0]         channel_total;
    logic               run_last;
    logic [1:0]         status;
  } out_t;

  localparam logic [1:0] ST_SAMPLE    = 2'd0;
  localparam logic [1:0] ST_BAD_DEPTH = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;

  localparam logic [1:0] DC_16 = 2'd0;
  localparam logic [1:0] DC_20 = 2'd1;
  localparam logic [1:0] DC_28 = 2'd3;

  localparam logic [7:0] FRAME_MASK = 8'hE0;

  typedef enum logic [1:0] {
    JOB_BLOCK,
    JOB_ERR_DEPTH,
    JOB_ERR_SHORT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [1:0] depth_code;
    logic [1:0] rate_code;
    logic [2:0] channel_code;
    logic [3:0] group_count;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERR,
    BK_HI0,
    BK_HI1,
    BK_HI2,
    BK_EMIT
  } back_state_t;

  function automatic logic [16:0] rate_of(input logic [1:0] code);
    case (code)
      2'd0:    rate_of = 17'd48000;
      2'd1:    rate_of = 17'd96000;
      2'd2:    rate_of = 17'd44100;
      default: rate_of = 17'd32000;
    endcase
  endfunction

  // groups per block for 20/24-bit layouts
  function automatic logic [3:0] groups_of(input logic [2:0] cc);
    case (cc)
      3'd0:    groups_of = 4'd2;
      3'd1:    groups_of = 4'd1;
      3'd3:    groups_of = 4'd1;
      3'd7:    groups_of = 4'd2;
      default: groups_of = {1'b0, cc} + 4'd1;
    endcase
  endfunction

  function automatic logic [6:0] block_bytes_of(input logic [1:0] dc, input logic [2:0] cc);
    logic [3:0] g;
    logic [6:0] per;
    g = groups_of(cc);
    if (cc == 3'd0) begin
      per = (dc == DC_20) ? 7'd5 : 7'd6;
    end else begin
      per = (dc == DC_20) ? 7'd10 : 7'd12;
    end
    if (dc == DC_16) begin
      block_bytes_of = {3'b000, cc, 1'b0} + 7'd2;
    end else begin
      block_bytes_of = 7'(per * {3'b000, g});
    end
  endfunction

endpackage

/* rtl/dvdlpcm_front.sv */
// Front end: header collection and parsing, payload fill of the block store.
// Depends on dvdlpcm_pkg; pushes jobs into dvdlpcm_jobq.
module dvdlpcm_front
  import dvdlpcm_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = 96,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_t           in_data,
  input  logic          q_full,
  output logic          job_push,
  output job_t          job_data,
  input  logic          blk_done,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam int FW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CW = (FW > 7) ? FW : 7;

  logic [23:0]   cached_r, cached_nxt;
  logic          hvalid_r, hvalid_nxt;
  logic [23:0]   shadow_r, shadow_nxt;
  logic [1:0]    hc_r, hc_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [6:0]    bb_r, bb_nxt;
  logic [3:0]    gc_r, gc_nxt;
  logic [1:0]    dc_r, dc_nxt;
  logic [2:0]    cc_r, cc_nxt;
  logic [1:0]    rc_r, rc_nxt;
  logic          drop_r, drop_nxt;
  logic          busy_r, busy_nxt;
  logic          pay;
  logic          fire;

  assign pay      = !in_data.packet_start && (hc_r == 2'd3) && !drop_r && hvalid_r;
  assign in_ready = !q_full && !(pay && busy_r);
  assign fire     = in_valid && in_ready;
  assign wr_addr  = fill_r[AW-1:0];
  assign wr_data  = in_data.data_byte;

  always_comb begin
    logic [1:0]    hc;
    logic          drop;
    logic [23:0]   hint;
    logic [7:0]    b1;
    logic [FW-1:0] fill_inc;
    cached_nxt = cached_r;
    hvalid_nxt = hvalid_r;
    shadow_nxt = shadow_r;
    hc_nxt     = hc_r;
    fill_nxt   = fill_r;
    bb_nxt     = bb_r;
    gc_nxt     = gc_r;
    dc_nxt     = dc_r;
    cc_nxt     = cc_r;
    rc_nxt     = rc_r;
    drop_nxt   = drop_r;
    busy_nxt   = busy_r && !blk_done;
    job_push   = 1'b0;
    job_data   = '{kind: JOB_BLOCK, depth_code: dc_r, rate_code: rc_r,
                   channel_code: cc_r, group_count: gc_r};
    wr_en      = 1'b0;
    hc         = in_data.packet_start ? 2'd0 : hc_r;
    drop       = in_data.packet_start ? 1'b0 : drop_r;
    b1         = shadow_r[15:8];
    hint       = {in_data.data_byte, shadow_r[15:8], shadow_r[7:0] & FRAME_MASK};
    fill_inc   = fill_r + FW'(1);
    if (fire) begin
      drop_nxt = drop;
      if (hc != 2'd3) begin
        case (hc)
          2'd0:    shadow_nxt = {16'h0000, in_data.data_byte};
          2'd1:    shadow_nxt = {8'h00, in_data.data_byte, shadow_r[7:0]};
          default: shadow_nxt = {in_data.data_byte, shadow_r[15:0]};
        endcase
        hc_nxt = hc + 2'd1;
        if (hc == 2'd2) begin
          if (!(hvalid_r && cached_r == hint)) begin
            hvalid_nxt = 1'b0;
            fill_nxt   = '0;
            if (b1[7:6] == DC_28) begin
              drop_nxt      = 1'b1;
              job_push      = 1'b1;
              job_data.kind = JOB_ERR_DEPTH;
            end else begin
              dc_nxt     = b1[7:6];
              rc_nxt     = b1[5:4];
              cc_nxt     = b1[2:0];
              gc_nxt     = (b1[7:6] == DC_16) ? 4'd0 : groups_of(b1[2:0]);
              bb_nxt     = block_bytes_of(b1[7:6], b1[2:0]);
              cached_nxt = hint;
              hvalid_nxt = 1'b1;
            end
          end
        end else if (in_data.packet_end) begin
          job_push      = 1'b1;
          job_data.kind = JOB_ERR_SHORT;
        end
      end else if (!drop && hvalid_r) begin
        if (fill_r < FW'(MAX_BLOCK_BYTES) && CW'(fill_r) < CW'(bb_r)) begin
          wr_en    = 1'b1;
          fill_nxt = fill_inc;
          if (CW'(fill_inc) >= CW'(bb_r)) begin
            // block complete: hand it to the back end and hold the store
            job_push = 1'b1;
            fill_nxt = '0;
            busy_nxt = 1'b1;
          end
        end else if (CW'(fill_r) >= CW'(bb_r)) begin
          job_push = 1'b1;
          fill_nxt = '0;
          busy_nxt = 1'b1;
        end
      end
      if (in_data.packet_end) begin
        hc_nxt   = 2'd0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_r <= '0;
      hvalid_r <= 1'b0;
      shadow_r <= '0;
      hc_r     <= '0;
      fill_r   <= '0;
      bb_r     <= '0;
      gc_r     <= '0;
      dc_r     <= '0;
      cc_r     <= '0;
      rc_r     <= '0;
      drop_r   <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      cached_r <= cached_nxt;
      hvalid_r <= hvalid_nxt;
      shadow_r <= shadow_nxt;
      hc_r     <= hc_nxt;
      fill_r   <= fill_nxt;
      bb_r     <= bb_nxt;
      gc_r     <= gc_nxt;
      dc_r     <= dc_nxt;
      cc_r     <= cc_nxt;
      rc_r     <= rc_nxt;
      drop_r   <= drop_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

/* rtl/dvdlpcm_jobq.sv */
// Two-entry job queue between the front and back ends.
// Depends on dvdlpcm_pkg for the job type.
module dvdlpcm_jobq
  import dvdlpcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = !wp_r;
    end
    if (pop && !empty) begin
      rp_nxt = !rp_r;
    end
    cnt_nxt = cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/dvdlpcm_back.sv */
// Back end: block store memory, sample assembly sequencer and output register.
// Depends on dvdlpcm_pkg; takes jobs from dvdlpcm_jobq.
module dvdlpcm_back
  import dvdlpcm_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = 96,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          q_empty,
  input  job_t          q_data,
  output logic          q_pop,
  output logic          blk_done,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data
);

  logic [7:0]    mem [MAX_BLOCK_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;

  back_state_t   st_r, st_nxt;
  job_t          job_r, job_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [2:0]    j_r, j_nxt;
  logic [3:0]    gi_r, gi_nxt;
  logic [2:0]    chn_r, chn_nxt;
  logic [15:0]   hi_r, hi_nxt;
  logic          ov_r, ov_nxt;
  out_t          od_r, od_nxt;

  logic [3:0]    ch;
  logic [3:0]    gsz;
  logic [3:0]    lob;
  logic [3:0]    ngroups;
  logic [AW-1:0] hi_addr;
  logic [AW-1:0] lo_addr;
  logic          out_free;
  logic          last_j;
  logic          last_g;

  assign ch       = {1'b0, job_r.channel_code} + 4'd1;
  assign gsz      = (job_r.depth_code == DC_16) ? ch : ((ch == 4'd1) ? 4'd2 : 4'd4);
  assign lob      = (job_r.depth_code == DC_20) ? {1'b0, gsz[3:1]} : gsz;
  assign ngroups  = (job_r.depth_code == DC_16) ? 4'd1 : job_r.group_count;
  assign hi_addr  = pos_r + AW'({j_r, 1'b0});
  assign lo_addr  = pos_r + AW'({gsz, 1'b0})
                  + AW'((job_r.depth_code == DC_20) ? {1'b0, j_r[2:1]} : j_r);
  assign out_free = !ov_r || out_ready;
  assign last_j   = ({1'b0, j_r} == gsz - 4'd1);
  assign last_g   = (gi_r == ngroups - 4'd1);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    st_nxt   = st_r;
    job_nxt  = job_r;
    pos_nxt  = pos_r;
    j_nxt    = j_r;
    gi_nxt   = gi_r;
    chn_nxt  = chn_r;
    hi_nxt   = hi_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    q_pop    = 1'b0;
    blk_done = 1'b0;
    rd_addr  = lo_addr;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_data;
          pos_nxt = '0;
          j_nxt   = '0;
          gi_nxt  = '0;
          chn_nxt = '0;
          st_nxt  = (q_data.kind == JOB_BLOCK) ? BK_HI0 : BK_ERR;
        end
      end
      BK_ERR: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt.status = (job_r.kind == JOB_ERR_DEPTH) ? ST_BAD_DEPTH : ST_SHORT;
          st_nxt = BK_IDLE;
        end
      end
      BK_HI0: begin
        rd_addr = hi_addr;
        st_nxt  = BK_HI1;
      end
      BK_HI1: begin
        rd_addr = hi_addr + AW'(1);
        hi_nxt  = {rd_data_r, hi_r[7:0]};
        st_nxt  = BK_HI2;
      end
      BK_HI2: begin
        hi_nxt = {hi_r[15:8], rd_data_r};
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        // low bits of the sample are on rd_data_r while lo_addr is held
        if (out_free) begin
          ov_nxt = 1'b1;
          case (job_r.depth_code)
            DC_16:   od_nxt.sample = {{16{hi_r[15]}}, hi_r};
            DC_20:   od_nxt.sample = {hi_r, (j_r[0] ? rd_data_r[3:0] : rd_data_r[7:4]), 12'h000};
            default: od_nxt.sample = {hi_r, rd_data_r, 8'h00};
          endcase
          od_nxt.channel       = chn_r;
          od_nxt.depth_bits    = 5'd16 + {1'b0, job_r.depth_code, 2'b00};
          od_nxt.rate_hz       = rate_of(job_r.rate_code);
          od_nxt.channel_total = ch;
          od_nxt.run_last      = last_j && last_g;
          od_nxt.status        = ST_SAMPLE;
          chn_nxt = ({1'b0, chn_r} == ch - 4'd1) ? 3'd0 : chn_r + 3'd1;
          if (last_j) begin
            j_nxt = '0;
            if (last_g) begin
              blk_done = 1'b1;
              st_nxt   = BK_IDLE;
            end else begin
              gi_nxt  = gi_r + 4'd1;
              pos_nxt = pos_r + AW'({gsz, 1'b0}) + AW'(lob);
              st_nxt  = BK_HI0;
            end
          end else begin
            j_nxt  = j_r + 3'd1;
            st_nxt = BK_HI0;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    pos_r <= pos_nxt;
    j_r   <= j_nxt;
    gi_r  <= gi_nxt;
    chn_r <= chn_nxt;
    hi_r  <= hi_nxt;
    od_r  <= od_nxt;
  end

endmodule

/* rtl/dvd_lpcm_stream_decoder_core.sv */
// DVD LPCM stream decoder: one packet byte per transfer in, decoded samples out.
// Header bytes are taken every cycle unless the two-entry job queue is full; payload bytes
// stall while the previous block is still being read out of the block store by the back end.
// Each sample passes through states HI0, HI1, HI2, EMIT (three store reads, one emit).
// Reset (rst_n low, synchronous) clears front-end registers, queue pointers, back-end state
// and output valid; back-end counters and data registers and the store are not cleared.
module dvd_lpcm_stream_decoder_core
  import dvdlpcm_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = 96
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(MAX_BLOCK_BYTES);

  logic          q_full;
  logic          q_empty;
  logic          job_push;
  logic          q_pop;
  job_t          job_in;
  job_t          job_out;
  logic          blk_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  dvdlpcm_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .AW(AW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .job_push (job_push),
    .job_data (job_in),
    .blk_done (blk_done),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  dvdlpcm_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (q_pop),
    .pop_data  (job_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  dvdlpcm_back #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_empty   (q_empty),
    .q_data    (job_out),
    .q_pop     (q_pop),
    .blk_done  (blk_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/dvdlpcm_checker.sv */
// Port-level checks for the DVD LPCM stream decoder, bound to the top level.
// Depends on dvdlpcm_pkg for the result type and status codes.
module dvdlpcm_checker
  import dvdlpcm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_SAMPLE |->
      out_data.sample == 0 && out_data.channel_total == 4'd0 && !out_data.run_last)
    else $error("error result carries sample fields");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAMPLE |->
      {1'b0, out_data.channel} < out_data.channel_total)
    else $error("channel index beyond channel total");

  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAMPLE && out_data.run_last |->
      {1'b0, out_data.channel} == out_data.channel_total - 4'd1)
    else $error("block ends off the last channel");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAMPLE |->
      out_data.depth_bits == 5'd16 || out_data.depth_bits == 5'd20 ||
      out_data.depth_bits == 5'd24)
    else $error("bad depth on sample");

endmodule

bind dvd_lpcm_stream_decoder_core dvdlpcm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
